FILE: hdl/modexp_pkg.sv
// shared types and constants of the modular exponentiation block
// no dependencies; used by modexp_mmul and modular_exponentiation
`default_nettype none

package modexp_pkg;

  // default operand width
  localparam int unsigned DefaultWidth = 16;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgExponent = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgModulus  = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRed  = 5'b00010,
    StMul  = 5'b00100,
    StSqr  = 5'b01000,
    StFin  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/modexp_mmul.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// depends on modexp_pkg for the default width
`default_nettype none

module modexp_mmul #(
  parameter int unsigned Width = modexp_pkg::DefaultWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] a_i,      // multiplicand, must not exceed m_i
  input  wire logic [Width-1:0] b_i,      // multiplier, taken at start
  input  wire logic [Width-1:0] m_i,      // modulus, nonzero, held while busy
  output logic                  done_o,
  output logic      [Width-1:0] res_o
);

  localparam int unsigned CntW = (Width > 1) ? $clog2(Width) : 1;
  localparam int unsigned TW   = Width + 2;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] b_q, b_d;
  logic [Width-1:0] r_q, r_d;

  logic [TW-1:0] t;
  logic [TW-1:0] m1;
  logic [TW-1:0] m2;
  logic [TW-1:0] t_red;

  // t = 2r + bit*a stays below 3m, so at most 2m comes off
  always_comb begin
    m1 = {2'b00, m_i};
    m2 = {1'b0, m_i, 1'b0};
    t  = {1'b0, r_q, 1'b0} + (b_q[Width-1] ? {2'b00, a_i} : '0);
    if (t >= m2) begin
      t_red = t - m2;
    end else if (t >= m1) begin
      t_red = t - m1;
    end else begin
      t_red = t;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    b_d    = b_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Width - 1);
      b_d    = b_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d = t_red[Width-1:0];
      b_d = {b_q[Width-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

`default_nettype wire

FILE: hdl/modular_exponentiation.sv
// top level: message ** exponent mod modulus by right-to-left square-and-multiply
// depends on modexp_pkg and modexp_mmul
`default_nettype none

// channel   direction  handshake               payload
// in        input      in_valid_i / in_stall_o   message_i
// out       output     out_valid_o / out_stall_i power_mod_o, bad_modulus_o
// cfg       input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// one request at a time through a single bit-serial modular multiplier; each
// request runs one reduction of the message, then a square for every exponent bit
// and a multiplication for every set exponent bit, one multiplication after the other
// a zero modulus skips the arithmetic and goes straight to the output register
// reset sets exponent and modulus to 1 and empties the output register
// in_stall_o is high while a request is being worked on; a finished result
// waits in the output register and the next request may be accepted meanwhile

module modular_exponentiation #(
  parameter int unsigned Width = modexp_pkg::DefaultWidth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [Width-1:0]               message_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [Width-1:0]               power_mod_o,
  output logic                                bad_modulus_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [modexp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [Width-1:0]               cfg_data_i
);

  localparam int unsigned BitW = (Width > 1) ? $clog2(Width) : 1;

  // configuration
  logic [Width-1:0] exponent_q, modulus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= Width'(1);
      modulus_q  <= Width'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        modexp_pkg::CfgExponent: exponent_q <= cfg_data_i;
        modexp_pkg::CfgModulus:  modulus_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  modexp_pkg::state_e state_q, state_d;
  logic             go_q, go_d;          // start pulse to the multiplier
  logic [BitW-1:0]  bit_q, bit_d;        // exponent bits still to go after the current one
  logic [Width-1:0] exp_q, exp_d;        // exponent, shifted right per bit
  logic [Width-1:0] acc_q, acc_d;        // running product
  logic [Width-1:0] sq_q, sq_d;          // running square (message at first)
  logic             bad_q, bad_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [Width-1:0] out_pm_q, out_pm_d;
  logic             out_bad_q, out_bad_d;

  // shared multiplier operands
  logic [Width-1:0] mm_a, mm_b, mm_res;
  logic             mm_done;

  logic in_take;
  logic out_free;

  assign in_take  = in_valid_i && (state_q == modexp_pkg::StIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  // reduce: msg * 1 mod m; multiply: acc * sq; square: sq * sq
  always_comb begin
    unique case (state_q)
      modexp_pkg::StRed: begin
        mm_a = Width'(1);
        mm_b = sq_q;
      end
      modexp_pkg::StMul: begin
        mm_a = sq_q;
        mm_b = acc_q;
      end
      default: begin
        mm_a = sq_q;
        mm_b = sq_q;
      end
    endcase
  end

  modexp_mmul #(
    .Width (Width)
  ) u_mmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (modulus_q),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  always_comb begin
    state_d     = state_q;
    go_d        = 1'b0;
    bit_d       = bit_q;
    exp_d       = exp_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_pm_d    = out_pm_q;
    out_bad_d   = out_bad_q;

    unique case (state_q)
      modexp_pkg::StIdle: begin
        if (in_take) begin
          sq_d  = message_i;
          exp_d = exponent_q;
          bit_d = BitW'(Width - 1);
          // 1 mod m: zero for a modulus of one
          acc_d = (modulus_q == Width'(1)) ? '0 : Width'(1);
          if (modulus_q == '0) begin
            bad_d   = 1'b1;
            acc_d   = '0;
            state_d = modexp_pkg::StFin;
          end else begin
            bad_d   = 1'b0;
            go_d    = 1'b1;
            state_d = modexp_pkg::StRed;
          end
        end
      end
      modexp_pkg::StRed: begin
        if (mm_done) begin
          sq_d    = mm_res;
          go_d    = 1'b1;
          state_d = exp_q[0] ? modexp_pkg::StMul : modexp_pkg::StSqr;
        end
      end
      modexp_pkg::StMul: begin
        if (mm_done) begin
          acc_d   = mm_res;
          go_d    = 1'b1;
          state_d = modexp_pkg::StSqr;
        end
      end
      modexp_pkg::StSqr: begin
        if (mm_done) begin
          sq_d = mm_res;
          if (bit_q == '0) begin
            state_d = modexp_pkg::StFin;
          end else begin
            bit_d   = bit_q - 1'b1;
            exp_d   = exp_q >> 1;
            go_d    = 1'b1;
            state_d = exp_q[1] ? modexp_pkg::StMul : modexp_pkg::StSqr;
          end
        end
      end
      modexp_pkg::StFin: begin
        // wait for room in the output register
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pm_d    = acc_q;
          out_bad_d   = bad_q;
          state_d     = modexp_pkg::StIdle;
        end
      end
      default: begin
        state_d = modexp_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= modexp_pkg::StIdle;
      go_q        <= 1'b0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q     <= exp_d;
    acc_q     <= acc_d;
    sq_q      <= sq_d;
    bad_q     <= bad_d;
    out_pm_q  <= out_pm_d;
    out_bad_q <= out_bad_d;
  end

  assign in_stall_o    = (state_q != modexp_pkg::StIdle);
  assign out_valid_o   = out_valid_q;
  assign power_mod_o   = out_pm_q;
  assign bad_modulus_o = out_bad_q;

endmodule

`default_nettype wire
